// ===== rtl/tcpf_pkg.sv =====
// Shared types and constants for the three-component polarity fix block.
package tcpf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int WIN_BITS    = 16;
  localparam int MODE_BITS   = 2;
  localparam int CORR_BITS   = 64;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int DOT_BITS    = SAMPLE_BITS + 2;
  localparam int NUM_COMP    = 3;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = Q_PTR_BITS + 1;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_WIN_FIRST = 2'd1;
  localparam logic [1:0] REG_WIN_LAST  = 2'd2;

  // Mode codes; any other code selects the hydrophone correlation
  localparam logic [MODE_BITS-1:0] MODE_MIN_PHASE  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_ZERO_PHASE = 2'd1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
    logic signed [SAMPLE_BITS-1:0] sample_p;
    logic signed [SAMPLE_BITS-1:0] vec_x;
    logic signed [SAMPLE_BITS-1:0] vec_y;
    logic signed [SAMPLE_BITS-1:0] vec_z;
    logic                          trace_end;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_x;
    logic signed [SAMPLE_BITS-1:0] out_y;
    logic signed [SAMPLE_BITS-1:0] out_z;
    logic                          flipped;
    logic [NUM_COMP-1:0]           comp_polarity;
  } result_t;

  typedef struct packed {
    logic seen;
    logic max_first;
    logic max_dominant;
    logic corr_negative;
  } lane_flags_t;

endpackage

// ===== rtl/tcpf_lane.sv =====
// One component lane: running min/max with positions and the p-correlation sum.
module tcpf_lane import tcpf_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          upd,
  input  logic                          last,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [PROD_BITS-1:0]   prod,
  input  logic [POSITION_BITS-1:0]      pos,
  output lane_flags_t                   flags
);

  logic                          seen;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic [POSITION_BITS-1:0]      min_pos;
  logic [POSITION_BITS-1:0]      max_pos;
  logic [CORR_BITS-1:0]          corr;

  logic                          seen_next;
  logic signed [SAMPLE_BITS-1:0] run_min_next;
  logic signed [SAMPLE_BITS-1:0] run_max_next;
  logic [POSITION_BITS-1:0]      min_pos_next;
  logic [POSITION_BITS-1:0]      max_pos_next;
  logic [CORR_BITS-1:0]          corr_next;

  logic                          snap_seen;
  logic signed [SAMPLE_BITS-1:0] snap_min;
  logic signed [SAMPLE_BITS-1:0] snap_max;
  logic [POSITION_BITS-1:0]      snap_min_pos;
  logic [POSITION_BITS-1:0]      snap_max_pos;
  logic [CORR_BITS-1:0]          snap_corr;

  logic signed [SAMPLE_BITS:0]   extreme_sum;

  always_comb begin
    seen_next    = seen;
    run_min_next = run_min;
    run_max_next = run_max;
    min_pos_next = min_pos;
    max_pos_next = max_pos;
    corr_next    = corr;
    if (upd) begin
      seen_next = 1'b1;
      if (!seen || sample < run_min) begin
        run_min_next = sample;
        min_pos_next = pos;
      end
      if (!seen || sample > run_max) begin
        run_max_next = sample;
        max_pos_next = pos;
      end
      corr_next = corr + CORR_BITS'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || last) begin
      seen    <= 1'b0;
      run_min <= '0;
      run_max <= '0;
      min_pos <= '0;
      max_pos <= '0;
      corr    <= '0;
    end else begin
      seen    <= seen_next;
      run_min <= run_min_next;
      run_max <= run_max_next;
      min_pos <= min_pos_next;
      max_pos <= max_pos_next;
      corr    <= corr_next;
    end
  end

  // Capture the trace's final statistics, this item included
  always_ff @(posedge clk) begin
    if (last) begin
      snap_seen    <= seen_next;
      snap_min     <= run_min_next;
      snap_max     <= run_max_next;
      snap_min_pos <= min_pos_next;
      snap_max_pos <= max_pos_next;
      snap_corr    <= corr_next;
    end
  end

  // max > -min  <=>  max + min > 0, one bit wider so nothing overflows
  assign extreme_sum = (SAMPLE_BITS + 1)'(snap_max) + (SAMPLE_BITS + 1)'(snap_min);

  always_comb begin
    flags.seen          = snap_seen;
    flags.max_first     = snap_max_pos < snap_min_pos;
    flags.max_dominant  = (extreme_sum > 0) && (snap_max > 0);
    flags.corr_negative = snap_corr[CORR_BITS-1];
  end

endmodule

// ===== rtl/tcpf_merge.sv =====
// Combines the lane decisions into polarities, the dot-product sign and the corrected vector.
module tcpf_merge import tcpf_pkg::*; (
  input  logic [MODE_BITS-1:0]          mode,
  input  lane_flags_t                   flags [NUM_COMP],
  input  logic signed [SAMPLE_BITS-1:0] vec   [NUM_COMP],
  output result_t                       result
);

  logic                          cond    [NUM_COMP];
  logic                          positive[NUM_COMP];
  logic signed [DOT_BITS-1:0]    dot;
  logic [NUM_COMP-1:0]           pol;
  logic                          flip;
  logic signed [SAMPLE_BITS-1:0] outv    [NUM_COMP];

  always_comb begin
    dot = '0;
    pol = '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      case (mode)
        MODE_MIN_PHASE:  cond[i] = flags[i].max_first;
        MODE_ZERO_PHASE: cond[i] = flags[i].max_dominant;
        default:         cond[i] = flags[i].corr_negative;
      endcase
      positive[i] = flags[i].seen && cond[i];
      if (positive[i]) begin
        dot = dot + DOT_BITS'(vec[i]);
      end else begin
        dot    = dot - DOT_BITS'(vec[i]);
        pol[i] = 1'b1;
      end
    end
    flip = dot[DOT_BITS-1];
    for (int i = 0; i < NUM_COMP; i++) begin
      if (!flip) begin
        outv[i] = vec[i];
      end else if (vec[i] == SAMPLE_MIN) begin
        outv[i] = SAMPLE_MAX;  // saturate the one value with no positive twin
      end else begin
        outv[i] = -vec[i];
      end
    end
  end

  always_comb begin
    result.out_x         = outv[0];
    result.out_y         = outv[1];
    result.out_z         = outv[2];
    result.flipped       = flip;
    result.comp_polarity = pol;
  end

endmodule

// ===== rtl/tcpf_outq.sv =====
// Small result queue that decouples the pipeline from the receiver.
module tcpf_outq import tcpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  output logic [Q_CNT_BITS-1:0] level
);

  result_t               mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic                  pop;

  assign result_valid = (level != '0);
  assign pop          = result_valid && result_ready;
  assign result       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

// ===== rtl/three_component_polarity_fix_top.sv =====
// Top level of the three-component polarity fix: input stage, lanes, merge and result queue.
//
// One x/y/z/p sample is transferred per cycle on the sample channel (valid/ready) while sample_ready is high.
// Samples are counted from 0 within a trace; those whose position lies in
// [window_first, window_last] feed three parallel lanes (x, y, z) that track the
// earliest min/max and the p-correlation sum. The sample marked trace_end closes
// the trace and yields one result on the result channel; other samples yield none.
// A trace's result passes the input stage, the lane snapshot and the result queue before it is offered.
// Throughput: one sample per cycle while the queue does not hold the input back.
// Results wait in a 4-entry queue; sample_ready drops only when the queue plus the
// trace ends still in the pipeline would fill it, so a stalled receiver holds the
// input back without losing or repeating results.
// Reset (rst, synchronous) clears the trace state, the queue and the registers
// mode, window_first and window_last. Write registers through the APB port only
// while no result is outstanding.
module three_component_polarity_fix_top import tcpf_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int CMP_BITS = (POSITION_BITS > WIN_BITS) ? POSITION_BITS : WIN_BITS;

  logic [MODE_BITS-1:0] mode;
  logic [WIN_BITS-1:0]  window_first;
  logic [WIN_BITS-1:0]  window_last;
  logic                 cfg_wr;

  logic                          accept;
  logic [POSITION_BITS-1:0]      position;
  logic                          in_window;

  logic                          s1_valid;
  logic                          s1_win;
  logic                          s1_end;
  logic [POSITION_BITS-1:0]      s1_pos;
  logic signed [SAMPLE_BITS-1:0] s1_sample [NUM_COMP];
  logic signed [PROD_BITS-1:0]   s1_prod   [NUM_COMP];
  logic signed [SAMPLE_BITS-1:0] s1_vec    [NUM_COMP];

  logic                          s2_end;
  logic signed [SAMPLE_BITS-1:0] s2_vec    [NUM_COMP];

  lane_flags_t                   flags     [NUM_COMP];
  result_t                       merged;
  logic [Q_CNT_BITS-1:0]         level;
  logic [Q_CNT_BITS-1:0]         committed;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= '0;
      window_first <= '0;
      window_last  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE:      mode         <= pwdata[MODE_BITS-1:0];
        REG_WIN_FIRST: window_first <= pwdata[WIN_BITS-1:0];
        REG_WIN_LAST:  window_last  <= pwdata[WIN_BITS-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:      prdata = DATA_BITS'(mode);
      REG_WIN_FIRST: prdata = DATA_BITS'(window_first);
      REG_WIN_LAST:  prdata = DATA_BITS'(window_last);
      default:       prdata = '0;
    endcase
  end

  // Reserve a queue slot for every trace end still in the pipeline
  assign committed    = level + Q_CNT_BITS'(s1_valid && s1_end) + Q_CNT_BITS'(s2_end);
  assign sample_ready = committed < Q_CNT_BITS'(Q_DEPTH);
  assign accept       = sample_valid && sample_ready;

  assign in_window = (CMP_BITS'(position) >= CMP_BITS'(window_first)) &&
                     (CMP_BITS'(position) <= CMP_BITS'(window_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      s1_valid <= 1'b0;
      s2_end   <= 1'b0;
    end else begin
      if (accept) begin
        position <= sample.trace_end ? '0 : position + 1'b1;
      end
      s1_valid <= accept;
      s2_end   <= s1_valid && s1_end;
    end
  end

  // Input stage: window check and the p products
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_win       <= in_window;
      s1_end       <= sample.trace_end;
      s1_pos       <= position;
      s1_sample[0] <= sample.sample_x;
      s1_sample[1] <= sample.sample_y;
      s1_sample[2] <= sample.sample_z;
      s1_prod[0]   <= sample.sample_p * sample.sample_x;
      s1_prod[1]   <= sample.sample_p * sample.sample_y;
      s1_prod[2]   <= sample.sample_p * sample.sample_z;
      s1_vec[0]    <= sample.vec_x;
      s1_vec[1]    <= sample.vec_y;
      s1_vec[2]    <= sample.vec_z;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_end) begin
      s2_vec <= s1_vec;
    end
  end

  for (genvar i = 0; i < NUM_COMP; i++) begin : g_lane
    tcpf_lane #(
      .POSITION_BITS(POSITION_BITS)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .upd   (s1_valid && s1_win),
      .last  (s1_valid && s1_end),
      .sample(s1_sample[i]),
      .prod  (s1_prod[i]),
      .pos   (s1_pos),
      .flags (flags[i])
    );
  end

  tcpf_merge u_merge (
    .mode  (mode),
    .flags (flags),
    .vec   (s2_vec),
    .result(merged)
  );

  tcpf_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (s2_end),
    .push_data   (merged),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .level       (level)
  );

endmodule
